[rtl/core/i2r_pkg.sv]
// ----------------------------------------------------------------------------
// i2r_pkg
// shared types, constants and helpers for the integer to radix digits unit
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int MAX_RADIX     = 16;
   localparam int DIGIT_SLOTS   = 32;
   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 8;
   localparam int RADIX_W       = 5;
   localparam int DIGIT_W       = 4;
   localparam int ALPHA_W       = 64;
   localparam int SLOT_IDX_W    = $clog2(DIGIT_SLOTS);
   localparam int COUNT_W       = SLOT_IDX_W + 1;
   localparam int CSR_IDX_W     = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;
   localparam int BYTE_STEPS    = VALUE_W / 8;
   localparam int STEP_W        = $clog2(BYTE_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_RADIX      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_HIGH = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
   localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
   localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h0000000000003938;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
   localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

   typedef struct packed {
      logic                bad;
      logic                neg;
      logic [VALUE_W-1:0]  mag;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ERROR,
      ST_SIGN,
      ST_EMIT
   } back_state_type;

   function automatic logic [CHAR_W-1:0] alpha_char(
      input logic [ALPHA_W-1:0] lo,
      input logic [ALPHA_W-1:0] hi,
      input logic [DIGIT_W-1:0] d
   );
      logic [5:0] sel;
      sel = {d[2:0], 3'b000};
      if (d[3]) begin
         alpha_char = hi[sel +: CHAR_W];
      end else begin
         alpha_char = lo[sel +: CHAR_W];
      end
   endfunction

endpackage

[rtl/core/i2r_front.sv]
// ----------------------------------------------------------------------------
// i2r_front
// takes requests, checks the configured base and forms the magnitude
// ----------------------------------------------------------------------------
module i2r_front
   import i2r_pkg::*;
(
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [RADIX_W-1:0]         radix,
   input  logic [ALPHA_W-1:0]         alpha_low,
   input  logic [ALPHA_W-1:0]         alpha_high,
   input  logic                       q_full,
   output logic                       q_push,
   output job_type                    q_job
);

   logic               base_ok;
   logic [VALUE_W-1:0] raw;

   always_comb begin
      logic [CHAR_W-1:0] ch [MAX_RADIX];
      logic              fail;
      fail = (radix < MIN_RADIX) || (radix > RADIX_W'(MAX_RADIX));
      for (int a = 0; a < MAX_RADIX; a++) begin
         ch[a] = alpha_char(alpha_low, alpha_high, DIGIT_W'(a));
      end
      for (int a = 0; a < MAX_RADIX; a++) begin
         if (RADIX_W'(a) < radix) begin
            if (ch[a] == CHAR_PLUS || ch[a] == CHAR_MINUS) begin
               fail = 1'b1;
            end
            for (int b = a + 1; b < MAX_RADIX; b++) begin
               if (RADIX_W'(b) < radix && ch[b] == ch[a]) begin
                  fail = 1'b1;
               end
            end
         end
      end
      base_ok = !fail;
   end

   assign raw       = req_value;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign q_job.bad = !base_ok;
   assign q_job.neg = raw[VALUE_W-1];
   assign q_job.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

endmodule

[rtl/core/i2r_queue.sv]
// ----------------------------------------------------------------------------
// i2r_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module i2r_queue
   import i2r_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  job_type  push_job,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output job_type  head_job
);

   job_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

[rtl/core/i2r_back.sv]
// ----------------------------------------------------------------------------
// i2r_back
// divides the magnitude down to digits, then emits sign and characters, or flags a bad base
// ----------------------------------------------------------------------------
module i2r_back
   import i2r_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [RADIX_W-1:0]   radix,
   input  logic [ALPHA_W-1:0]   alpha_low,
   input  logic [ALPHA_W-1:0]   alpha_high,
   input  logic                 q_not_empty,
   input  job_type              q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAR_W-1:0]    rsp_char_out,
   output logic                 rsp_is_last,
   output logic                 rsp_bad_base
);

   back_state_type             state_ff, state_in;
   logic [VALUE_W-1:0]         mag_ff, mag_in;
   logic [VALUE_W-1:0]         quot_ff, quot_in;
   logic [DIGIT_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       neg_ff, neg_in;
   logic [DIGIT_W-1:0]         digit_store_ff [DIGIT_SLOTS];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]          rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_bad_ff, rsp_bad_in;

   logic                       out_free;
   logic                       load_out;
   logic                       last_step;
   logic                       div_done;
   logic                       store_write;
   logic [DIGIT_W-1:0]         rem_new;
   logic [7:0]                 qbits;
   logic [VALUE_W-1:0]         quot_full;
   logic [COUNT_W-1:0]         idx_wide;
   logic [SLOT_IDX_W-1:0]      emit_idx;
   logic [DIGIT_W-1:0]         emit_digit;

   // one byte of long division per cycle
   always_comb begin
      logic [RADIX_W-1:0] part;
      logic [DIGIT_W-1:0] r;
      r = (step_ff == '0) ? '0 : rem_ff;
      qbits = '0;
      for (int i = 0; i < 8; i++) begin
         part = {r, mag_ff[VALUE_W-1-i]};
         if (part >= radix) begin
            qbits[7-i] = 1'b1;
            part       = part - radix;
         end
         r = part[DIGIT_W-1:0];
      end
      rem_new = r;
   end

   assign quot_full  = {quot_ff[VALUE_W-9:0], qbits};
   assign last_step  = (step_ff == STEP_W'(BYTE_STEPS - 1));
   assign div_done   = (quot_full == '0) || (count_ff == COUNT_W'(DIGIT_SLOTS - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign idx_wide   = count_ff - COUNT_W'(1);
   assign emit_idx   = idx_wide[SLOT_IDX_W-1:0];
   assign emit_digit = digit_store_ff[emit_idx];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = q_job.bad ? ST_ERROR : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (last_step && div_done) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_ERROR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && count_ff == COUNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output controls
   always_comb begin
      q_pop       = 1'b0;
      load_out    = 1'b0;
      store_write = 1'b0;
      mag_in      = mag_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      neg_in      = neg_ff;
      rsp_char_in = CHAR_NONE;
      rsp_last_in = 1'b0;
      rsp_bad_in  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               mag_in   = q_job.mag;
               neg_in   = q_job.neg;
               count_in = '0;
               step_in  = '0;
            end
         end
         ST_DIVIDE: begin
            rem_in  = rem_new;
            step_in = step_ff + 1'b1;
            if (last_step) begin
               store_write = 1'b1;
               mag_in      = quot_full;
               count_in    = count_ff + 1'b1;
            end else begin
               mag_in  = {mag_ff[VALUE_W-9:0], 8'h00};
               quot_in = quot_full;
            end
         end
         ST_ERROR: begin
            load_out    = out_free;
            rsp_last_in = 1'b1;
            rsp_bad_in  = 1'b1;
         end
         ST_SIGN: begin
            load_out    = out_free;
            rsp_char_in = CHAR_MINUS;
         end
         ST_EMIT: begin
            load_out    = out_free;
            rsp_char_in = alpha_char(alpha_low, alpha_high, emit_digit);
            rsp_last_in = (count_ff == COUNT_W'(1));
            if (out_free) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         mag_ff       <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      if (load_out) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
      if (store_write) begin
         digit_store_ff[count_ff[SLOT_IDX_W-1:0]] <= rem_new;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_is_last  = rsp_last_ff;
   assign rsp_bad_base = rsp_bad_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DIGIT_SLOTS))
      else $error("digit count above slot count");

   a_emit_has_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT || state_ff == ST_SIGN) |-> count_ff != '0)
      else $error("emitting with no digits");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_last_ff && rsp_char_ff == CHAR_NONE))
      else $error("malformed error result");

endmodule

[rtl/core/integer_to_radix_digits_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// signed 32-bit value to digit characters in a configurable base
//
//   channel   dir   handshake            payload
//   req_      in    req_valid/stall      req_value
//   rsp_      out   rsp_valid/stall      rsp_char_out, rsp_is_last, rsp_bad_base
//   csr_      in    csr_write            csr_index, csr_data
//
// the divider in the back end retires one byte of the magnitude per cycle and
// yields one digit per pass over the magnitude; the digits are then emitted,
// after a minus sign for a negative value. an invalid base gives one error result.
// reset loads the default base ten alphabet and empties the two-entry queue.
// rsp_stall holds the output register; the front keeps taking requests until
// the queue is full.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit
   import i2r_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [CHAR_W-1:0]          rsp_char_out,
   output logic                       rsp_is_last,
   output logic                       rsp_bad_base,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [ALPHA_W-1:0]         csr_data
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [ALPHA_W-1:0] alpha_low_ff, alpha_low_in;
   logic [ALPHA_W-1:0] alpha_high_ff, alpha_high_in;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_not_empty;
   job_type  front_job;
   job_type  head_job;

   always_comb begin
      radix_in      = radix_ff;
      alpha_low_in  = alpha_low_ff;
      alpha_high_in = alpha_high_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_RADIX:      radix_in      = csr_data[RADIX_W-1:0];
            CSR_ALPHA_LOW:  alpha_low_in  = csr_data;
            CSR_ALPHA_HIGH: alpha_high_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         alpha_low_ff  <= ALPHA_LOW_RESET;
         alpha_high_ff <= ALPHA_HIGH_RESET;
      end else begin
         radix_ff      <= radix_in;
         alpha_low_ff  <= alpha_low_in;
         alpha_high_ff <= alpha_high_in;
      end
   end

   i2r_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .radix      (radix_ff),
      .alpha_low  (alpha_low_ff),
      .alpha_high (alpha_high_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (front_job)
   );

   i2r_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   i2r_back u_back (
      .clock        (clock),
      .reset        (reset),
      .radix        (radix_ff),
      .alpha_low    (alpha_low_ff),
      .alpha_high   (alpha_high_ff),
      .q_not_empty  (q_not_empty),
      .q_job        (head_job),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_is_last  (rsp_is_last),
      .rsp_bad_base (rsp_bad_base)
   );

endmodule
